### rtl/mtf_pkg.sv
package mtf_pkg;

  // transaction kind codes
  localparam logic [1:0] KIND_TOUCH  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] entry_id;
    logic [4:0] position;
  } mtf_in_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] found_position;
    logic       grew;
    logic       dropped;
    logic [5:0] count;
    logic [7:0] read_entry;
    logic       read_valid;
  } mtf_out_t;

  // per-cell control: load from the bus or take the neighbor's entry
  typedef struct packed {
    logic load;
    logic take;
  } mtf_cell_ctl_t;

endpackage

### rtl/mtf_if.sv
interface mtf_in_if;
  import mtf_pkg::*;
  logic    valid;
  logic    ready;
  mtf_in_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface mtf_out_if;
  import mtf_pkg::*;
  logic     valid;
  logic     ready;
  mtf_out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/move_to_front_recency_list.sv
// channel   dir  handshake      payload
// in_ch     in   valid/ready    kind, entry_id, position
// out_ch    out  valid/ready    hit, found_position, grew, dropped, count,
//                               read_entry, read_valid
//
// one transaction per cycle while the output queue has room: every cell compares and shifts in the same cycle,
// so the figure is set by the cell row plus the first-match priority pick.
// a result is registered into the output queue when its transaction is accepted.
// a two-entry output queue keeps input accepting while one result waits.
// reset (rst_n low, synchronous) empties the list and the queue; slot contents
// are not cleared, only entries below the count are ever read.
module move_to_front_recency_list #(
  parameter int LIST_DEPTH = 32,
  parameter int ID_BITS    = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  mtf_in_if.sink   in_ch,
  mtf_out_if.source out_ch
);
  import mtf_pkg::*;

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W = $clog2(LIST_DEPTH);

  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic [ID_BITS-1:0]    key;
  logic [ID_BITS-1:0]    slot_id [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] cell_match;
  logic [LIST_DEPTH-1:0] below_cnt;
  logic [LIST_DEPTH-1:0] upto_cnt;
  logic [LIST_DEPTH-1:0] at_cnt;
  logic [LIST_DEPTH-1:0] match_vec;
  logic [LIST_DEPTH-1:0] first_oh;
  logic [LIST_DEPTH-1:0] upto_hit;
  logic [LIST_DEPTH-1:0] shift_mask;
  mtf_cell_ctl_t         cell_ctl [LIST_DEPTH];
  logic [IDX_W-1:0]      fpos;
  logic [IDX_W-1:0]      rd_idx;
  logic                  acc;
  logic                  is_touch;
  logic                  is_append;
  logic                  is_read;
  logic                  full;
  logic                  hit;
  logic                  grew;
  logic                  dropped;
  logic                  rval;
  logic                  can_push;
  mtf_out_t              result;

  assign acc         = in_ch.valid && in_ch.ready;
  assign in_ch.ready = can_push;
  assign is_touch    = (in_ch.payload.kind == KIND_TOUCH);
  assign is_append   = (in_ch.payload.kind == KIND_APPEND);
  assign is_read     = (in_ch.payload.kind == KIND_READ);
  assign key         = ID_BITS'(in_ch.payload.entry_id);
  assign full        = (count_r == CNT_W'(LIST_DEPTH));

  genvar g;
  generate
    for (g = 0; g < LIST_DEPTH; g++) begin : g_cell
      logic [ID_BITS-1:0] prev_id;
      if (g == 0) begin : g_head
        assign prev_id = key;
      end else begin : g_body
        assign prev_id = slot_id[g-1];
      end

      assign below_cnt[g] = (CNT_W'(g) < count_r);
      assign upto_cnt[g]  = (CNT_W'(g) <= count_r);
      assign at_cnt[g]    = (CNT_W'(g) == count_r);

      always_comb begin
        cell_ctl[g].load = acc && ((is_touch && (g == 0)) ||
                                   (is_append && at_cnt[g] && !full));
        cell_ctl[g].take = acc && is_touch && (g != 0) && shift_mask[g];
      end

      mtf_cell #(
        .ID_BITS (ID_BITS)
      ) u_cell (
        .clk     (clk),
        .ctl     (cell_ctl[g]),
        .load_id (key),
        .prev_id (prev_id),
        .key     (key),
        .slot_id (slot_id[g]),
        .match   (cell_match[g])
      );
    end
  endgenerate

  // nearest-to-head match, and the mask of cells up to and including it
  assign match_vec  = cell_match & below_cnt;
  assign first_oh   = match_vec & (~match_vec + LIST_DEPTH'(1));
  assign upto_hit   = first_oh | (first_oh - LIST_DEPTH'(1));
  assign hit        = |match_vec;
  assign shift_mask = hit ? upto_hit : upto_cnt;

  always_comb begin
    fpos = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if (first_oh[i]) begin
        fpos = fpos | IDX_W'(i);
      end
    end
  end

  assign grew    = (is_touch && !hit && !full) || (is_append && !full);
  assign dropped = (is_touch && !hit && full) || (is_append && full);
  assign rd_idx  = IDX_W'(in_ch.payload.position);
  assign rval    = is_read && (32'(in_ch.payload.position) < 32'(count_r));

  always_comb begin
    count_nxt = count_r;
    if (grew) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_comb begin
    result.hit            = is_touch && hit;
    result.found_position = (is_touch && hit) ? 5'(fpos) : 5'd0;
    result.grew           = grew;
    result.dropped        = dropped;
    result.count          = 6'(count_nxt);
    result.read_entry     = rval ? 8'(slot_id[rd_idx]) : 8'd0;
    result.read_valid     = rval;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (acc) begin
      count_r <= count_nxt;
    end
  end

  mtf_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_data (result),
    .push      (acc),
    .can_push  (can_push),
    .out_ch    (out_ch)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(LIST_DEPTH))
    else $error("list count beyond depth");

  a_touch_head: assert property (@(posedge clk) disable iff (!rst_n)
    acc && is_touch |=> slot_id[0] == $past(key))
    else $error("touched id not at head");

  a_grew_count: assert property (@(posedge clk) disable iff (!rst_n)
    acc && grew |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("count did not follow grew");

  a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    hit |-> $onehot(first_oh))
    else $error("first match not unique");

endmodule

### rtl/mtf_cell.sv
module mtf_cell #(
  parameter int ID_BITS = 8
) (
  input  logic                  clk,
  input  mtf_pkg::mtf_cell_ctl_t ctl,
  input  logic [ID_BITS-1:0]    load_id,
  input  logic [ID_BITS-1:0]    prev_id,
  input  logic [ID_BITS-1:0]    key,
  output logic [ID_BITS-1:0]    slot_id,
  output logic                  match
);
  import mtf_pkg::*;

  logic [ID_BITS-1:0] slot_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      slot_r <= load_id;
    end else if (ctl.take) begin
      slot_r <= prev_id;
    end
  end

  assign slot_id = slot_r;
  assign match   = (slot_r == key);

endmodule

### rtl/mtf_out_fifo.sv
module mtf_out_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  mtf_pkg::mtf_out_t push_data,
  input  logic             push,
  output logic             can_push,
  mtf_out_if.source        out_ch
);
  import mtf_pkg::*;

  logic [1:0] fill_r;
  logic [1:0] fill_nxt;
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  mtf_out_t   slot0_r;
  mtf_out_t   slot1_r;
  logic       pop;

  assign can_push       = (fill_r != 2'd2);
  assign out_ch.valid   = (fill_r != 2'd0);
  assign out_ch.payload = rd_ptr_r ? slot1_r : slot0_r;
  assign pop            = out_ch.valid && out_ch.ready;

  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !wr_ptr_r) begin
      slot0_r <= push_data;
    end
    if (push && wr_ptr_r) begin
      slot1_r <= push_data;
    end
  end

endmodule
